/* rtl/core/hdrm_pkg.sv */
// Shared types, constants and codes of the HDR exposure merge block.
`timescale 1ns / 1ps
package hdrm_pkg;

   localparam int TABLE_BITS_DEFAULT = 10;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int SUM_W       = 56;
   localparam int ACC_W       = 40;
   localparam int SCORE_W     = 48;
   localparam int OUT_W       = 32;
   localparam int PART_W      = 20;
   localparam int DIV_STEPS   = 32;
   localparam int STEP_W      = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_BLACK_OFFSET      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SATURATION_OFFSET = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE             = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WHITE_RED         = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WHITE_GREEN       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_WHITE_BLUE        = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_USE_BEST          = 3'd6;

   localparam logic CMD_SAMPLE      = 1'b0;
   localparam logic CMD_TABLE_WRITE = 1'b1;

   typedef struct packed {
      logic       req_ready;
      logic       prod;
      logic       upd;
      logic       best;
      logic       mul0;
      logic       mul1;
      logic       div_init;
      logic       div_step;
      logic       store;
      logic       out;
      logic [1:0] chan;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_is_sample;
      logic last;
      logic px_under;
      logic px_over;
      logic use_best;
      logic rsp_free;
   } ctrl_sts_type;

endpackage

/* rtl/core/hdrm_req_if.sv */
// Input channel interface carrying pixel samples and weight table writes.
`timescale 1ns / 1ps
interface hdrm_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [15:0] red;
   logic [15:0] green;
   logic [15:0] blue;
   logic [31:0] exp_comp;
   logic [31:0] inv_exp_comp;
   logic        last_frame;
   logic [9:0]  table_index;
   logic [15:0] table_weight;

   modport source (output valid, cmd, red, green, blue, exp_comp, inv_exp_comp, last_frame,
                   table_index, table_weight, input ready);
   modport sink (input valid, cmd, red, green, blue, exp_comp, inv_exp_comp, last_frame,
                 table_index, table_weight, output ready);
endinterface

/* rtl/core/hdrm_rsp_if.sv */
// Result channel interface carrying merged pixels.
`timescale 1ns / 1ps
interface hdrm_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_red;
   logic [31:0] out_green;
   logic [31:0] out_blue;
   logic [1:0]  status;

   modport source (output valid, out_red, out_green, out_blue, status, input ready);
   modport sink (input valid, out_red, out_green, out_blue, status, output ready);
endinterface

/* rtl/core/rgb_hdr_exposure_merge.sv */
// Top level of the RGB HDR exposure merge block.
`timescale 1ns / 1ps
// Merges one RGB pixel over a run of exposure samples into a weighted-mean or
// best-frame radiance. A weight table write is taken while idle, and a sample
// that is not the last of its pixel goes through a table read, products and an
// update. The last sample then passes a mode step and adds its result: straight
// to the output when all frames are under or over or the weight sum is zero, a
// best-frame step first, or, for the weighted mean, two multiply steps and a
// shared radix-2 divider that the three channels go through in turn. A new item
// is accepted while a finished result still waits in the output register.
module rgb_hdr_exposure_merge #(
   parameter int TABLE_BITS = hdrm_pkg::TABLE_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [hdrm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hdrm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   hdrm_req_if.sink                         req_ch,
   hdrm_rsp_if.source                       rsp_ch
);

   hdrm_pkg::ctrl_cmd_type cmd;
   hdrm_pkg::ctrl_sts_type sts;

   hdrm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   hdrm_datapath #(
      .TABLE_BITS (TABLE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

/* rtl/core/hdrm_ctrl.sv */
// Controller state machine sequencing accumulation and the final merge.
`timescale 1ns / 1ps
module hdrm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  hdrm_pkg::ctrl_sts_type sts,
   output hdrm_pkg::ctrl_cmd_type cmd
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_PROD     = 4'd1;
   localparam logic [3:0] ST_UPD      = 4'd2;
   localparam logic [3:0] ST_MODE     = 4'd3;
   localparam logic [3:0] ST_BEST     = 4'd4;
   localparam logic [3:0] ST_MUL0     = 4'd5;
   localparam logic [3:0] ST_MUL1     = 4'd6;
   localparam logic [3:0] ST_DIV_INIT = 4'd7;
   localparam logic [3:0] ST_DIV      = 4'd8;
   localparam logic [3:0] ST_STORE    = 4'd9;
   localparam logic [3:0] ST_OUT      = 4'd10;

   logic [3:0]                  state_ff, state_in;
   logic [1:0]                  chan_ff, chan_in;
   logic [hdrm_pkg::STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      chan_in  = chan_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (sts.req_valid && sts.req_is_sample) begin
               state_in = ST_PROD;
            end
         end
         ST_PROD: state_in = ST_UPD;
         ST_UPD: state_in = sts.last ? ST_MODE : ST_IDLE;
         ST_MODE: begin
            chan_in = 2'd0;
            if (sts.px_under || sts.px_over) begin
               state_in = ST_OUT;
            end else if (sts.use_best) begin
               state_in = ST_BEST;
            end else begin
               state_in = ST_MUL0;
            end
         end
         ST_BEST: state_in = ST_OUT;
         ST_MUL0: state_in = ST_MUL1;
         ST_MUL1: state_in = ST_DIV_INIT;
         ST_DIV_INIT: begin
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            step_in = step_ff + 1'b1;
            if (step_ff == hdrm_pkg::STEP_W'(hdrm_pkg::DIV_STEPS - 1)) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            if (chan_ff == 2'd2) begin
               state_in = ST_OUT;
            end else begin
               chan_in  = chan_ff + 1'b1;
               state_in = ST_MUL0;
            end
         end
         ST_OUT: begin
            if (sts.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chan_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.req_ready = (state_ff == ST_IDLE);
      cmd.prod      = (state_ff == ST_PROD);
      cmd.upd       = (state_ff == ST_UPD);
      cmd.best      = (state_ff == ST_BEST);
      cmd.mul0      = (state_ff == ST_MUL0);
      cmd.mul1      = (state_ff == ST_MUL1);
      cmd.div_init  = (state_ff == ST_DIV_INIT);
      cmd.div_step  = (state_ff == ST_DIV);
      cmd.store     = (state_ff == ST_STORE);
      cmd.out       = (state_ff == ST_OUT) && sts.rsp_free;
      cmd.chan      = chan_ff;
   end

   a_upd_after_prod: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPD |-> $past(state_ff) == ST_PROD)
      else $error("update step without a product step");

   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && !sts.rsp_free |=> state_ff == ST_OUT)
      else $error("result dropped while the output stage is full");

   a_mean_mode: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL0 |-> !sts.px_under && !sts.px_over && !sts.use_best)
      else $error("weighted mean started in a bypass mode");

   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> chan_ff != 2'd3)
      else $error("channel counter out of range");

endmodule

/* rtl/core/hdrm_datapath.sv */
// Datapath: configuration, weight table, accumulators, divider and output stage.
`timescale 1ns / 1ps
module hdrm_datapath #(
   parameter int TABLE_BITS = hdrm_pkg::TABLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [hdrm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [hdrm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   hdrm_req_if.sink                            req_ch,
   hdrm_rsp_if.source                          rsp_ch,
   input  hdrm_pkg::ctrl_cmd_type              cmd,
   output hdrm_pkg::ctrl_sts_type              sts
);

   localparam int DEPTH = 1 << TABLE_BITS;

   logic [15:0]                 black_ff, satoff_ff;
   logic [23:0]                 scale_ff;
   logic [16:0]                 white_ff [3];
   logic                        use_best_ff;

   logic [15:0]                 mem [DEPTH];
   logic [15:0]                 wa_ff, wb_ff;

   logic [15:0]                 v_ff [3];
   logic [31:0]                 ec_ff, inv_ff;
   logic                        last_ff, over_ff, under_ff;

   logic [hdrm_pkg::SCORE_W-1:0] score_ff;
   logic [31:0]                 wv_ff [3];
   logic [31:0]                 hq_ff [3];
   logic [31:0]                 lq_ff [3];

   logic [hdrm_pkg::SUM_W-1:0]   ws_ff;
   logic [hdrm_pkg::ACC_W-1:0]   acc_ff [3];
   logic [31:0]                 high_ff [3];
   logic [31:0]                 low_ff [3];
   logic [hdrm_pkg::SCORE_W-1:0] best_score_ff;
   logic                        best_valid_ff;
   logic [31:0]                 best_ff [3];
   logic                        under_all_ff, over_all_ff;

   logic [43:0]                 pp0_ff, pp1_ff;
   logic [hdrm_pkg::SUM_W-1:0]   rem_ff;
   logic [31:0]                 qsh_ff;
   logic                        sat_ff;
   logic [31:0]                 res_ff [3];

   logic                        rsp_valid_ff;
   logic [31:0]                 out_ff [3];
   logic [1:0]                  status_ff;

   logic [15:0]                 v_in [3];
   logic [15:0]                 hi, lo;
   logic                        over_in, under_in;
   logic [TABLE_BITS-1:0]       hi_idx, lo_idx, wr_idx;
   logic                        accept, tbl_we, sample_we;
   logic [15:0]                 w;
   logic                        in_range, better, ws_zero;
   logic [hdrm_pkg::SUM_W:0]     ws_sum;
   logic [63:0]                 num;
   logic [hdrm_pkg::SUM_W:0]     trial;
   logic                        ge;
   logic [1:0]                  ch;

   assign v_in[0] = req_ch.red;
   assign v_in[1] = req_ch.green;
   assign v_in[2] = req_ch.blue;

   always_comb begin
      hi = v_in[0];
      lo = v_in[0];
      for (int c = 1; c < 3; c++) begin
         if (v_in[c] > hi) hi = v_in[c];
         if (v_in[c] < lo) lo = v_in[c];
      end
   end

   assign over_in   = {1'b0, hi} >= (17'h10000 - {1'b0, satoff_ff});
   assign under_in  = lo <= black_ff;
   assign hi_idx    = hi[15 -: TABLE_BITS];
   assign lo_idx    = lo[15 -: TABLE_BITS];
   assign wr_idx    = TABLE_BITS'(req_ch.table_index);
   assign accept    = req_ch.valid && cmd.req_ready;
   assign tbl_we    = accept && (req_ch.cmd == hdrm_pkg::CMD_TABLE_WRITE);
   assign sample_we = accept && (req_ch.cmd == hdrm_pkg::CMD_SAMPLE);
   assign req_ch.ready = cmd.req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         black_ff    <= '0;
         satoff_ff   <= '0;
         scale_ff    <= 24'h010000;
         white_ff[0] <= 17'h10000;
         white_ff[1] <= 17'h10000;
         white_ff[2] <= 17'h10000;
         use_best_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            hdrm_pkg::CSR_BLACK_OFFSET:      black_ff    <= csr_wdata[15:0];
            hdrm_pkg::CSR_SATURATION_OFFSET: satoff_ff   <= csr_wdata[15:0];
            hdrm_pkg::CSR_SCALE:             scale_ff    <= csr_wdata;
            hdrm_pkg::CSR_WHITE_RED:         white_ff[0] <= csr_wdata[16:0];
            hdrm_pkg::CSR_WHITE_GREEN:       white_ff[1] <= csr_wdata[16:0];
            hdrm_pkg::CSR_WHITE_BLUE:        white_ff[2] <= csr_wdata[16:0];
            hdrm_pkg::CSR_USE_BEST:          use_best_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         mem[wr_idx] <= req_ch.table_weight;
      end
      wa_ff <= mem[hi_idx];
      wb_ff <= mem[lo_idx];
   end

   always_ff @(posedge clock) begin
      if (sample_we) begin
         for (int c = 0; c < 3; c++) v_ff[c] <= v_in[c];
         ec_ff    <= req_ch.exp_comp;
         inv_ff   <= req_ch.inv_exp_comp;
         last_ff  <= req_ch.last_frame;
         over_ff  <= over_in;
         under_ff <= under_in;
      end
   end

   assign w = (wa_ff < wb_ff) ? wa_ff : wb_ff;

   always_ff @(posedge clock) begin
      if (cmd.prod) begin
         score_ff <= hdrm_pkg::SCORE_W'({32'b0, w} * {16'b0, ec_ff});
         for (int c = 0; c < 3; c++) begin
            logic [15:0] capped;
            logic [47:0] hp, lp;
            capped    = ({1'b0, v_ff[c]} < white_ff[c]) ? v_ff[c] : white_ff[c][15:0];
            hp        = {32'b0, capped} * {16'b0, inv_ff};
            lp        = {32'b0, v_ff[c]} * {16'b0, inv_ff};
            wv_ff[c] <= 32'({16'b0, w} * {16'b0, v_ff[c]});
            hq_ff[c] <= hp[47:16];
            lq_ff[c] <= lp[47:16];
         end
      end
   end

   assign in_range = !(over_ff || under_ff);
   assign better   = !best_valid_ff || (score_ff > best_score_ff);
   assign ws_sum   = {1'b0, ws_ff} + {9'b0, score_ff};
   assign ws_zero  = (ws_ff == '0);

   always_ff @(posedge clock) begin
      if (reset || cmd.out) begin
         ws_ff         <= '0;
         best_score_ff <= '0;
         best_valid_ff <= 1'b0;
         under_all_ff  <= 1'b1;
         over_all_ff   <= 1'b1;
         for (int c = 0; c < 3; c++) begin
            acc_ff[c]  <= '0;
            high_ff[c] <= '0;
            low_ff[c]  <= '1;
            best_ff[c] <= '0;
         end
      end else if (cmd.upd) begin
         under_all_ff <= under_all_ff && under_ff;
         over_all_ff  <= over_all_ff && over_ff;
         if (in_range) begin
            ws_ff <= ws_sum[hdrm_pkg::SUM_W] ? '1 : ws_sum[hdrm_pkg::SUM_W-1:0];
            if (better) begin
               best_valid_ff <= 1'b1;
               best_score_ff <= score_ff;
               for (int c = 0; c < 3; c++) best_ff[c] <= lq_ff[c];
            end
         end
         for (int c = 0; c < 3; c++) begin
            logic [hdrm_pkg::ACC_W:0] asum;
            asum = {1'b0, acc_ff[c]} + {9'b0, wv_ff[c]};
            if (in_range) begin
               acc_ff[c] <= asum[hdrm_pkg::ACC_W] ? '1 : asum[hdrm_pkg::ACC_W-1:0];
            end
            if (hq_ff[c] > high_ff[c]) high_ff[c] <= hq_ff[c];
            if (lq_ff[c] < low_ff[c]) low_ff[c] <= lq_ff[c];
         end
      end
   end

   assign ch    = cmd.chan;
   assign num   = {20'b0, pp0_ff} + {pp1_ff, 20'b0};
   assign trial = {rem_ff, qsh_ff[31]};
   assign ge    = trial >= {1'b0, ws_ff};

   always_ff @(posedge clock) begin
      if (cmd.mul0) begin
         pp0_ff <= {24'b0, acc_ff[ch][hdrm_pkg::PART_W-1:0]} * {20'b0, scale_ff};
      end
      if (cmd.mul1) begin
         pp1_ff <= {24'b0, acc_ff[ch][hdrm_pkg::ACC_W-1:hdrm_pkg::PART_W]} * {20'b0, scale_ff};
      end
      if (cmd.div_init) begin
         sat_ff <= {24'b0, num[63:32]} >= ws_ff;
         rem_ff <= {24'b0, num[63:32]};
         qsh_ff <= num[31:0];
      end else if (cmd.div_step) begin
         rem_ff <= ge ? hdrm_pkg::SUM_W'(trial - {1'b0, ws_ff})
                      : trial[hdrm_pkg::SUM_W-1:0];
         qsh_ff <= {qsh_ff[30:0], ge};
      end
      if (cmd.store) begin
         res_ff[ch] <= sat_ff ? '1 : qsh_ff;
      end
      if (cmd.best) begin
         for (int c = 0; c < 3; c++) begin
            logic [55:0] bp;
            bp = {32'b0, scale_ff} * {24'b0, best_ff[c]};
            res_ff[c] <= (bp[55:48] != 8'b0) ? '1 : bp[47:16];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out) begin
         status_ff <= {sts.px_over, sts.px_under};
         for (int c = 0; c < 3; c++) begin
            if (sts.px_under) begin
               out_ff[c] <= low_ff[c];
            end else if (sts.px_over) begin
               out_ff[c] <= high_ff[c];
            end else begin
               out_ff[c] <= res_ff[c];
            end
         end
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_red   = out_ff[0];
   assign rsp_ch.out_green = out_ff[1];
   assign rsp_ch.out_blue  = out_ff[2];
   assign rsp_ch.status    = status_ff;

   always_comb begin
      sts               = '0;
      sts.req_valid     = req_ch.valid;
      sts.req_is_sample = (req_ch.cmd == hdrm_pkg::CMD_SAMPLE);
      sts.last          = last_ff;
      sts.px_under      = under_all_ff;
      sts.px_over       = over_all_ff || ws_zero;
      sts.use_best      = use_best_ff;
      sts.rsp_free      = !rsp_valid_ff || rsp_ch.ready;
   end

endmodule
